// ===== rtl/ps2md_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - shared definitions
// Header bit positions, register map, queue sizing and the packet record
// passed from the byte assembler to the report stage.
// ----------------------------------------------------------------------------
package ps2md_pkg;

    // packet queue depth between assembler and report stage
    localparam int unsigned FIFO_DEPTH = 2;

    // APB register port
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // register index (byte address / 4)
    localparam logic [0:0] REG_IDX_WHEEL_MODE = 1'b0;

    // header byte fields
    localparam logic [7:0] HDR_ALWAYS_ONE = 8'h08;
    localparam logic [7:0] HDR_OVERFLOW   = 8'hC0;
    localparam int unsigned HDR_LEFT_BIT   = 0;
    localparam int unsigned HDR_RIGHT_BIT  = 1;
    localparam int unsigned HDR_MIDDLE_BIT = 2;
    localparam int unsigned HDR_XSIGN_BIT  = 4;
    localparam int unsigned HDR_YSIGN_BIT  = 5;

    // one assembled packet
    typedef struct packed {
        logic [7:0] hdr;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] wheel;
    } t_pkt;

endpackage

// ===== rtl/ps2md_rx_if.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - received byte channel
// Valid/ready channel carrying one byte from the mouse receiver.
// ----------------------------------------------------------------------------
interface ps2md_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ps2md_rpt_if.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - report channel
// Valid/ready channel carrying one decoded mouse report.
// ----------------------------------------------------------------------------
interface ps2md_rpt_if;
    logic              valid;
    logic              ready;
    logic              left_button;
    logic              middle_button;
    logic              right_button;
    logic [2:0]        buttons_changed;
    logic signed [8:0] delta_x;
    logic signed [9:0] delta_y;
    logic signed [7:0] delta_wheel;
    logic              moved;
    logic              scrolled;

    modport source (
        output valid, output left_button, output middle_button, output right_button,
        output buttons_changed, output delta_x, output delta_y, output delta_wheel,
        output moved, output scrolled, input ready
    );
    modport sink (
        input valid, input left_button, input middle_button, input right_button,
        input buttons_changed, input delta_x, input delta_y, input delta_wheel,
        input moved, input scrolled, output ready
    );
endinterface

// ===== rtl/ps2md_front.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - byte assembler
// Checks header bytes, collects X, Y and wheel bytes, pushes whole packets.
// ----------------------------------------------------------------------------
module ps2md_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wheel_mode,
    ps2md_rx_if.sink           i_rx,
    input  logic               i_q_full,
    output logic               o_q_push,
    output ps2md_pkg::t_pkt    o_q_data
);
    import ps2md_pkg::*;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2,
        POS_WHEEL  = 2'd3
    } t_pos;

    t_pos       r_pos, n_pos;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_x, n_x;
    logic [7:0] r_y, n_y;
    logic       w_accept;
    logic [7:0] w_byte;

    // ready does not look at the byte, only at queue space
    assign i_rx.ready = !i_q_full;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_byte     = i_rx.rx_byte;

    always_comb begin
        n_pos    = r_pos;
        n_hdr    = r_hdr;
        n_x      = r_x;
        n_y      = r_y;
        o_q_push = 1'b0;
        o_q_data = '{hdr: r_hdr, x: r_x, y: r_y, wheel: 8'h00};
        if (w_accept) begin
            unique case (r_pos)
                POS_HEADER: begin
                    if (((w_byte & HDR_ALWAYS_ONE) != 8'h00) &&
                        ((w_byte & HDR_OVERFLOW) == 8'h00)) begin
                        n_hdr = w_byte;
                        n_pos = POS_X;
                    end
                end
                POS_X: begin
                    n_x   = w_byte;
                    n_pos = POS_Y;
                end
                POS_Y: begin
                    n_y = w_byte;
                    if (i_wheel_mode) begin
                        n_pos = POS_WHEEL;
                    end else begin
                        o_q_push   = 1'b1;
                        o_q_data.y = w_byte;
                        n_pos      = POS_HEADER;
                    end
                end
                POS_WHEEL: begin
                    o_q_push = 1'b1;
                    n_pos    = POS_HEADER;
                    if (i_wheel_mode) begin
                        o_q_data.wheel = w_byte;
                    end else begin
                        // mode dropped mid-packet: this byte is the Y byte
                        n_y        = w_byte;
                        o_q_data.y = w_byte;
                    end
                end
                default: n_pos = POS_HEADER;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HEADER;
        end else begin
            r_pos <= n_pos;
        end
        r_hdr <= n_hdr;
        r_x   <= n_x;
        r_y   <= n_y;
    end

endmodule

// ===== rtl/ps2md_fifo.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - packet queue
// Small FIFO of assembled packets between assembler and report stage.
// ----------------------------------------------------------------------------
module ps2md_fifo #(
    parameter int unsigned DEPTH = ps2md_pkg::FIFO_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ps2md_pkg::t_pkt    i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output ps2md_pkg::t_pkt    o_data
);
    import ps2md_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/ps2md_back.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - report stage
// Turns a packet into a report and holds it in the output register.
// ----------------------------------------------------------------------------
module ps2md_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  ps2md_pkg::t_pkt    i_q_data,
    output logic               o_q_pop,
    ps2md_rpt_if.source        o_rpt
);
    import ps2md_pkg::*;

    logic              r_valid;
    logic [2:0]        r_last_btn;
    logic [2:0]        r_btn, n_btn;
    logic [2:0]        r_changed, n_changed;
    logic signed [8:0] r_dx, n_dx;
    logic [9:0]        r_dy, n_dy;
    logic signed [7:0] r_dw, n_dw;
    logic              r_moved, n_moved;
    logic              r_scrolled, n_scrolled;
    logic              w_ysign;

    // load a new report when the register is empty or being drained
    assign o_q_pop = i_q_valid && (!r_valid || o_rpt.ready);
    assign w_ysign = i_q_data.hdr[HDR_YSIGN_BIT];

    always_comb begin
        n_btn      = {i_q_data.hdr[HDR_RIGHT_BIT], i_q_data.hdr[HDR_MIDDLE_BIT],
                      i_q_data.hdr[HDR_LEFT_BIT]};
        n_changed  = n_btn ^ r_last_btn;
        n_moved    = (i_q_data.x != 8'h00) || (i_q_data.y != 8'h00);
        n_dx       = n_moved ? $signed({i_q_data.hdr[HDR_XSIGN_BIT], i_q_data.x}) : '0;
        // negate the sign-extended nine-bit Y so that down is positive
        n_dy       = n_moved ? (10'd0 - {w_ysign, w_ysign, i_q_data.y}) : '0;
        n_dw       = $signed(i_q_data.wheel);
        n_scrolled = (i_q_data.wheel != 8'h00);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_last_btn <= '0;
        end else begin
            if (o_q_pop) begin
                r_valid    <= 1'b1;
                r_last_btn <= n_btn;
            end else if (o_rpt.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_btn      <= n_btn;
            r_changed  <= n_changed;
            r_dx       <= n_dx;
            r_dy       <= n_dy;
            r_dw       <= n_dw;
            r_moved    <= n_moved;
            r_scrolled <= n_scrolled;
        end
    end

    assign o_rpt.valid           = r_valid;
    assign o_rpt.left_button     = r_btn[0];
    assign o_rpt.middle_button   = r_btn[1];
    assign o_rpt.right_button    = r_btn[2];
    assign o_rpt.buttons_changed = r_changed;
    assign o_rpt.delta_x         = r_dx;
    assign o_rpt.delta_y         = $signed(r_dy);
    assign o_rpt.delta_wheel     = r_dw;
    assign o_rpt.moved           = r_moved;
    assign o_rpt.scrolled        = r_scrolled;

endmodule

// ===== rtl/ps2_mouse_packet_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - top level
// Byte assembler, packet queue and report stage behind an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx  : one received mouse byte per transfer (valid/ready).
//   o_rpt : one decoded report per complete packet (valid/ready).
//   APB   : register 0 (byte address 0) is wheel_mode, bit 0. Write it only
//           while no packet is in flight. pready is tied high.
// Throughput: one byte per cycle. i_rx.ready is low only while the packet
//   queue is full, so a byte is taken even while a report waits on o_rpt.
// A packet is written into the queue when its last byte is transferred;
//   its report is built as it leaves the queue and shows on o_rpt from
//   the output register, loaded once that register is empty or drained.
// Header bytes without bit 3 or with an overflow bit set are dropped
//   without a report. Three-byte packets, or four with wheel_mode = 1.
// Reset (synchronous, active low) empties the queue, drops any partial
//   packet, drops a pending report, clears button history and wheel_mode.
// When the receiver stalls o_rpt, the report holds; the queue keeps
//   absorbing up to QUEUE_DEPTH further packets before i_rx.ready drops.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = ps2md_pkg::FIFO_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ps2md_rx_if.sink                      i_rx,
    ps2md_rpt_if.source                   o_rpt,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ps2md_pkg::APB_AW-1:0]  paddr,
    input  logic [ps2md_pkg::APB_DW-1:0]  pwdata,
    output logic [ps2md_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import ps2md_pkg::*;

    logic       r_wheel_mode;
    logic [0:0] w_reg_idx;
    logic       w_q_full;
    logic       w_q_push;
    t_pkt       w_q_wdata;
    logic       w_q_valid;
    logic       w_q_pop;
    t_pkt       w_q_rdata;

    // register index is the word address; low two bits are byte lanes
    assign w_reg_idx = paddr[APB_AW-1 -: 1];
    assign pready    = 1'b1;
    assign prdata    = (w_reg_idx == REG_IDX_WHEEL_MODE) ?
                       {{(APB_DW-1){1'b0}}, r_wheel_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     (w_reg_idx == REG_IDX_WHEEL_MODE)) begin
            r_wheel_mode <= pwdata[0];
        end
    end

    // front: header check and byte collection
    ps2md_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wheel_mode (r_wheel_mode),
        .i_rx         (i_rx),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_wdata)
    );

    // decouples byte intake from report backpressure
    ps2md_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    // back: report build, button history, output register
    ps2md_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .o_rpt     (o_rpt)
    );

endmodule

// ===== rtl/ps2md_chk.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - port checker
// Concurrent checks on the report channel, bound to the top level.
// ----------------------------------------------------------------------------
module ps2md_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [5:0]        i_buttons,
    input logic signed [8:0] i_dx,
    input logic signed [9:0] i_dy,
    input logic signed [7:0] i_dw,
    input logic              i_moved,
    input logic              i_scrolled
);

    // a stalled report holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_buttons) && $stable(i_dx) &&
        $stable(i_dy) && $stable(i_dw) && $stable(i_moved) && $stable(i_scrolled))
        else $error("report changed while stalled");

    // reset leaves no report pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("report valid after reset");

    // no movement means both deltas read zero
    a_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_moved |-> (i_dx == 9'sd0) && (i_dy == 10'sd0))
        else $error("nonzero delta without movement");

    // scrolled flag tracks the wheel delta
    a_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_scrolled == (i_dw != 8'sd0)))
        else $error("scrolled flag mismatch");

endmodule

bind ps2_mouse_packet_decoder_unit ps2md_chk u_ps2md_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_rpt.valid),
    .i_ready    (o_rpt.ready),
    .i_buttons  ({o_rpt.left_button, o_rpt.middle_button, o_rpt.right_button,
                  o_rpt.buttons_changed}),
    .i_dx       (o_rpt.delta_x),
    .i_dy       (o_rpt.delta_y),
    .i_dw       (o_rpt.delta_wheel),
    .i_moved    (o_rpt.moved),
    .i_scrolled (o_rpt.scrolled)
);

// ===== dv/ps2_mouse_packet_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder - testbench
// Drives received mouse bytes into the decoder and checks every report
// against a cycle-free software predictor of the packet assembler. The run
// covers header rejection, both packet lengths, sign and zero-motion edge
// cases, a mode switch inside a packet, and random traffic with idles,
// back-pressure and a long receiver stall.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2md_pkg::*;

    // cycles to let the report path settle once nothing is expected
    localparam int DRAIN_SETTLE = 4;
    // length of the long receiver hold-off, in cycles
    localparam int RX_LONG_HOLD = 300;
    localparam int PHASE_BYTES  = 185;
    localparam logic [APB_AW-1:0] WHEEL_MODE_ADDR = {REG_IDX_WHEEL_MODE, 2'b00};

    // one decoded mouse report, same fields as the report channel
    typedef struct packed {
        logic              left;
        logic              middle;
        logic              right;
        logic [2:0]        changed;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
        logic signed [7:0] dw;
        logic              moved;
        logic              scrolled;
    } t_mouse_report;

    // ------------------------------------------------------------------------
    // Predictor plus report queue. note_byte() runs the byte assembler for
    // every accepted transfer; check_report() pops the oldest report.
    // ------------------------------------------------------------------------
    class mouse_report_scoreboard;
        logic          wheel_mode;
        logic [1:0]    byte_pos;
        logic [7:0]    hdr_byte;
        logic [7:0]    x_byte;
        logic [7:0]    y_byte;
        logic [2:0]    last_btn;
        t_mouse_report report_q[$];
        int            mismatches;
        int            bytes_noted;
        int            headers_dropped;
        int            reports_checked;
        int            scroll_reports;

        function new();
            wheel_mode      = 1'b0;
            byte_pos        = 2'd0;
            hdr_byte        = '0;
            x_byte          = '0;
            y_byte          = '0;
            last_btn        = '0;
            mismatches      = 0;
            bytes_noted     = 0;
            headers_dropped = 0;
            reports_checked = 0;
            scroll_reports  = 0;
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function void set_mode(logic m);
            wheel_mode = m;
        endfunction

        function void close_packet(logic [7:0] wheel);
            t_mouse_report r;
            logic [2:0]    btn;
            // bit0 left, bit1 middle, bit2 right
            btn        = {hdr_byte[HDR_RIGHT_BIT], hdr_byte[HDR_MIDDLE_BIT],
                          hdr_byte[HDR_LEFT_BIT]};
            r.left     = btn[0];
            r.middle   = btn[1];
            r.right    = btn[2];
            r.changed  = btn ^ last_btn;
            r.moved    = (x_byte != 8'd0) || (y_byte != 8'd0);
            // no motion forces both deltas to zero, sign bits ignored
            r.dx       = r.moved ? {hdr_byte[HDR_XSIGN_BIT], x_byte} : '0;
            if (!r.moved) begin
                r.dy = '0;
            end else if (hdr_byte[HDR_YSIGN_BIT]) begin
                r.dy = 10'd256 - {2'b00, y_byte};
            end else begin
                r.dy = 10'd0 - {2'b00, y_byte};
            end
            r.dw       = wheel;
            r.scrolled = (wheel != 8'd0);
            if (r.scrolled) scroll_reports++;
            last_btn = btn;
            byte_pos = 2'd0;
            report_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            bytes_noted++;
            case (byte_pos)
                2'd0: begin
                    if ((b & HDR_ALWAYS_ONE) == 8'd0 || (b & HDR_OVERFLOW) != 8'd0) begin
                        headers_dropped++;
                    end else begin
                        hdr_byte = b;
                        byte_pos = 2'd1;
                    end
                end
                2'd1: begin
                    x_byte   = b;
                    byte_pos = 2'd2;
                end
                2'd2: begin
                    y_byte = b;
                    if (wheel_mode) byte_pos = 2'd3;
                    else close_packet(8'd0);
                end
                default: begin
                    // mode cleared mid-packet: this byte becomes the Y byte
                    if (wheel_mode) begin
                        close_packet(b);
                    end else begin
                        y_byte = b;
                        close_packet(8'd0);
                    end
                end
            endcase
        endfunction

        function void check_report(t_mouse_report got);
            t_mouse_report exp;
            string         diff;
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected report: %p", $realtime, got);
                return;
            end
            exp  = report_q.pop_front();
            diff = "";
            reports_checked++;
            if (got.left     !== exp.left)     diff = {diff, " left_button"};
            if (got.middle   !== exp.middle)   diff = {diff, " middle_button"};
            if (got.right    !== exp.right)    diff = {diff, " right_button"};
            if (got.changed  !== exp.changed)  diff = {diff, " buttons_changed"};
            if (got.dx       !== exp.dx)       diff = {diff, " delta_x"};
            if (got.dy       !== exp.dy)       diff = {diff, " delta_y"};
            if (got.dw       !== exp.dw)       diff = {diff, " delta_wheel"};
            if (got.moved    !== exp.moved)    diff = {diff, " moved"};
            if (got.scrolled !== exp.scrolled) diff = {diff, " scrolled"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] report %0d bad field(s):%s", $realtime,
                             reports_checked, diff);
                    $display("    exp %p", exp);
                    $display("    got %p", got);
                end
            end
        endfunction

        function void check_mode_readback(logic [31:0] rd);
            if (rd !== {31'd0, wheel_mode}) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] wheel_mode readback exp %0d got %h", $realtime,
                             wheel_mode, rd);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and channels
    // ------------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    ps2md_rx_if  rx_ch ();
    ps2md_rpt_if rpt_ch ();

    mouse_report_scoreboard sb;

    // stimulus knobs shared with the byte sender and the report receiver process
    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold_req;
    int mode_writes;

    ps2_mouse_packet_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_rpt   (rpt_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Report side: random stall bursts plus one long hold-off on request.
    // Sampling at the edge sees pre-edge values, so there is no race with
    // the DUT's own register updates.
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        rpt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rpt_ch.ready <= 1'b0;
            end else if (rx_hold_req) begin
                // long hold: queue fills and the byte input must back up
                rx_hold_req = 1'b0;
                stall_left  = RX_LONG_HOLD - 1;
                rpt_ch.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 11);
                rpt_ch.ready <= 1'b0;
            end else begin
                rpt_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_mouse_report got;
        if (i_rst_n && rpt_ch.valid && rpt_ch.ready) begin
            got.left     = rpt_ch.left_button;
            got.middle   = rpt_ch.middle_button;
            got.right    = rpt_ch.right_button;
            got.changed  = rpt_ch.buttons_changed;
            got.dx       = rpt_ch.delta_x;
            got.dy       = rpt_ch.delta_y;
            got.dw       = rpt_ch.delta_wheel;
            got.moved    = rpt_ch.moved;
            got.scrolled = rpt_ch.scrolled;
            sb.check_report(got);
        end
    end

    // ------------------------------------------------------------------------
    // Byte side tasks. Every task starts and ends on a rising edge; valid is
    // left high between back-to-back transfers and only dropped for a gap or a drain.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!(rx_ch.valid && rx_ch.ready));
        sb.note_byte(b);
    endtask

    // stop sending, wait for every outstanding report, then let the
    // pipeline finish any byte that produced no report
    task automatic wait_drain();
        rx_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // APB write of wheel_mode while idle, then read it back
    task automatic set_wheel_mode(input logic m);
        logic [31:0] rd;
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WHEEL_MODE_ADDR;
        pwdata  <= {31'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_mode(m);
        mode_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.check_mode_readback(rd);
    endtask

    // Mostly well-formed packets with random content; some packets are cut
    // short and some stray bytes are mixed in to knock framing about.
    task automatic run_traffic(input int n_bytes);
        int         sent;
        int         len;
        logic [7:0] b;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(0, 99) < 88) begin
                len = sb.wheel_mode ? 4 : 3;
                if ($urandom_range(0, 19) == 0) len = $urandom_range(1, len - 1);
                for (int k = 0; k < len; k++) begin
                    if (k == 0) begin
                        // buttons and sign bits random, always-one set, no overflow
                        b = (8'($urandom) & 8'h37) | HDR_ALWAYS_ONE;
                    end else if ($urandom_range(0, 5) == 0) begin
                        b = 8'h00;
                    end else begin
                        b = 8'($urandom);
                    end
                    send_byte(b);
                end
                sent += len;
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] dir_std [18];
        logic [7:0] dir_wheel [7];

        // bad headers first, then 3-byte packets at the motion extremes
        dir_std = '{
            8'h00, 8'hC8, 8'h48,     // bit 3 clear, both overflow, one overflow
            8'h3F, 8'h00, 8'h00,     // all buttons, signs set, zero motion
            8'h3F, 8'hFF, 8'hFF,     // dx -1, dy +1
            8'h0A, 8'hFF, 8'hFF,     // right only, dx +255, dy -255
            8'h18, 8'h00, 8'h01,     // dx -256 (X sign, zero X byte)
            8'h28, 8'h01, 8'h00      // dy +256 (Y sign, zero Y byte)
        };
        // wheel packet with the most negative scroll, then a partial packet
        dir_wheel = '{
            8'h0C, 8'h01, 8'h01, 8'h80,
            8'h08, 8'h05, 8'h06
        };

        sb = new();
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        rx_hold_req = 1'b0;
        mode_writes = 0;

        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_std[i]) send_byte(dir_std[i]);

        set_wheel_mode(1'b1);
        foreach (dir_wheel[i]) send_byte(dir_wheel[i]);
        // leave wheel mode with three bytes held: the next byte is the Y byte
        set_wheel_mode(1'b0);
        send_byte(8'h09);

        for (int p = 0; p < 5; p++) begin
            set_wheel_mode(p % 2 == 0);
            if (p == 1) rx_hold_req = 1'b1;
            if (p == 4) begin
                // closing stretch at full rate on both sides
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            run_traffic(PHASE_BYTES);
            if (p == 1) begin
                // sender pause until the report queue is empty
                wait_drain();
                run_traffic(PHASE_BYTES / 2);
            end
        end

        wait_drain();
        repeat (4 * DRAIN_SETTLE) @(posedge i_clk);

        $display("Run: %0d bytes in (%0d rejected headers), %0d reports checked, %0d scrolled,",
                 sb.bytes_noted, sb.headers_dropped, sb.reports_checked, sb.scroll_reports);
        $display("     %0d wheel_mode writes, one long report stall, %0d mismatches.",
                 mode_writes, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ps2md_pkg.sv
rtl/ps2md_rx_if.sv
rtl/ps2md_rpt_if.sv
rtl/ps2md_front.sv
rtl/ps2md_fifo.sv
rtl/ps2md_back.sv
rtl/ps2_mouse_packet_decoder_unit.sv
rtl/ps2md_chk.sv
dv/ps2_mouse_packet_decoder_unit_tb.sv
